### sv/irpd_pkg.sv
`default_nettype none

package irpd_pkg;

    localparam int BITS_PER_FRAME = 16;
    localparam int TIME_BITS      = 32;
    localparam int TABLE_SIZE     = 12;
    localparam int THR_BITS       = 16;
    localparam int CODE_BITS      = 16;
    localparam int COUNT_BITS     = 5;
    localparam int BUTTON_BITS    = 4;
    localparam int CFG_IDX_BITS   = 3;

    typedef logic [TIME_BITS-1:0]   time_t;
    typedef logic [THR_BITS-1:0]    ticks_t;
    typedef logic [CODE_BITS-1:0]   code_t;
    typedef logic [COUNT_BITS-1:0]  count_t;
    typedef logic [BUTTON_BITS-1:0] button_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_HEADER_MIN    = 3'd0,
        REG_GAP_MIN       = 3'd1,
        REG_ONE_MIN       = 3'd2,
        REG_ZERO_MIN      = 3'd3,
        REG_REPEAT_WINDOW = 3'd4
    } cfg_reg_t;

    localparam ticks_t HEADER_MIN_RESET    = 16'd80;
    localparam ticks_t GAP_MIN_RESET       = 16'd39;
    localparam ticks_t ONE_MIN_RESET       = 16'd10;
    localparam ticks_t ZERO_MIN_RESET      = 16'd4;
    localparam ticks_t REPEAT_WINDOW_RESET = 16'd500;

    typedef struct packed {
        ticks_t header_min;
        ticks_t gap_min;
        ticks_t one_min;
        ticks_t zero_min;
    } thresholds_t;

    typedef enum logic [2:0] {
        KIND_SHORT,
        KIND_ZERO,
        KIND_ONE,
        KIND_GAP,
        KIND_HEADER
    } interval_kind_t;

    typedef struct packed {
        logic    hit;
        button_t index;
    } lookup_t;

    localparam code_t CODE_TABLE [TABLE_SIZE] = '{
        16'hA800, 16'hA880, 16'hA840, 16'hA8C0, 16'hA820, 16'hA8A0,
        16'hA860, 16'hA8E0, 16'hA810, 16'hA890, 16'hA830, 16'hA854
    };

    // First matching entry wins; scanning downward leaves the lowest index.
    function automatic lookup_t code_lookup(input code_t code);
        lookup_t res;
        res = '0;
        for (int i = TABLE_SIZE - 1; i >= 0; i--) begin
            if (CODE_TABLE[i] == code) begin
                res.hit   = 1'b1;
                res.index = BUTTON_BITS'(i);
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

### sv/irpd_classify.sv
`default_nettype none

module irpd_classify
    import irpd_pkg::*;
(
    input  wire time_t          interval,
    input  wire thresholds_t    thr,
    output interval_kind_t      kind
);

    // Thresholds are tested in priority order, even if they are out of order.
    always_comb
    begin
        if (interval >= TIME_BITS'(thr.header_min)) begin
            kind = KIND_HEADER;
        end else if (interval >= TIME_BITS'(thr.gap_min)) begin
            kind = KIND_GAP;
        end else if (interval >= TIME_BITS'(thr.one_min)) begin
            kind = KIND_ONE;
        end else if (interval >= TIME_BITS'(thr.zero_min)) begin
            kind = KIND_ZERO;
        end else begin
            kind = KIND_SHORT;
        end
    end

endmodule

`default_nettype wire

### sv/ir_pulse_distance_decoder_unit.sv
// IR remote pulse-distance decoder.
// Input channel (in_valid/in_ready, edge_time): one word per edge seen on
// the receiver line, stamped with a free-running tick count.
// Output channel (out_valid/out_ready, matched/button/raw_code): one word
// per completed 16-bit frame that is not a repeat of a latched press.
// Configuration: cfg_write with cfg_index/cfg_data writes one of five 16-bit
// thresholds; write only while the block is idle.
// Each accepted edge updates the decoder state in the cycle it is taken;
// a resulting word is loaded into the output register at that same clock edge.
// Throughput is one edge per cycle: the state update is a single pass of
// a 32-bit subtract and four threshold compares.
// If the output word is not taken, in_ready drops until it is, so no word
// is lost; while out_ready is high, edges flow at full rate.
// Reset restores the default thresholds, clears the frame and press state
// and empties the output register.
`default_nettype none

module ir_pulse_distance_decoder_unit
    import irpd_pkg::*;
(
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     cfg_write,
    input  wire [CFG_IDX_BITS-1:0]  cfg_index,
    input  wire [THR_BITS-1:0]      cfg_data,
    input  wire                     in_valid,
    output logic                    in_ready,
    input  wire [TIME_BITS-1:0]     edge_time,
    output logic                    out_valid,
    input  wire                     out_ready,
    output logic                    matched,
    output logic [BUTTON_BITS-1:0]  button,
    output logic [CODE_BITS-1:0]    raw_code
);

    thresholds_t thr_reg;
    ticks_t      window_reg;

    logic   start_valid_reg, start_valid_next;
    time_t  start_time_reg, start_time_next;
    code_t  shift_reg, shift_next;
    count_t count_reg, count_next;
    logic   press_reg, press_next;
    time_t  press_time_reg, press_time_next;

    logic    out_valid_reg, out_valid_next;
    logic    matched_reg, matched_next;
    button_t button_reg, button_next;
    code_t   raw_reg, raw_next;

    logic           accept;
    time_t          interval;
    time_t          since_press;
    interval_kind_t kind;
    lookup_t        hit;
    count_t         count_step;
    code_t          shift_step;
    logic           emit;

    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign matched   = matched_reg;
    assign button    = button_reg;
    assign raw_code  = raw_reg;

    assign interval    = edge_time - start_time_reg;
    assign since_press = edge_time - press_time_reg;

    irpd_classify u_classify (
        .interval (interval),
        .thr      (thr_reg),
        .kind     (kind)
    );

    always_comb
    begin
        start_valid_next = start_valid_reg;
        start_time_next  = start_time_reg;
        press_next       = press_reg;
        press_time_next  = press_time_reg;
        count_step       = count_reg;
        shift_step       = shift_reg;
        emit             = 1'b0;

        if (!start_valid_reg) begin
            start_time_next  = edge_time;
            start_valid_next = 1'b1;
            if (press_reg) begin
                press_time_next = edge_time;
            end
        end else begin
            case (kind)
                KIND_HEADER:
                begin
                    start_time_next = edge_time;
                    count_step      = '0;
                    shift_step      = '0;
                    if (press_reg && (since_press > TIME_BITS'(window_reg))) begin
                        press_next = 1'b0;
                    end
                end
                KIND_GAP:
                begin
                    start_valid_next = 1'b0;
                end
                KIND_ONE, KIND_ZERO:
                begin
                    shift_step       = {shift_reg[CODE_BITS-2:0], kind == KIND_ONE};
                    count_step       = count_reg + count_t'(1);
                    start_valid_next = 1'b0;
                end
                default:
                begin
                end
            endcase
        end

        hit        = code_lookup(shift_step);
        count_next = count_step;
        shift_next = shift_step;
        if (count_step == count_t'(BITS_PER_FRAME)) begin
            emit       = !press_next;
            press_next = 1'b1;
            count_next = '0;
            shift_next = '0;
        end

        out_valid_next = out_valid_reg && !out_ready;
        matched_next   = matched_reg;
        button_next    = button_reg;
        raw_next       = raw_reg;
        if (accept && emit) begin
            out_valid_next = 1'b1;
            matched_next   = hit.hit;
            button_next    = hit.index;
            raw_next       = shift_step;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            thr_reg.header_min <= HEADER_MIN_RESET;
            thr_reg.gap_min    <= GAP_MIN_RESET;
            thr_reg.one_min    <= ONE_MIN_RESET;
            thr_reg.zero_min   <= ZERO_MIN_RESET;
            window_reg         <= REPEAT_WINDOW_RESET;
        end else if (cfg_write) begin
            case (cfg_index)
                REG_HEADER_MIN:    thr_reg.header_min <= cfg_data;
                REG_GAP_MIN:       thr_reg.gap_min    <= cfg_data;
                REG_ONE_MIN:       thr_reg.one_min    <= cfg_data;
                REG_ZERO_MIN:      thr_reg.zero_min   <= cfg_data;
                REG_REPEAT_WINDOW: window_reg         <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            start_valid_reg <= 1'b0;
            start_time_reg  <= '0;
            shift_reg       <= '0;
            count_reg       <= '0;
            press_reg       <= 1'b0;
            press_time_reg  <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (accept) begin
                start_valid_reg <= start_valid_next;
                start_time_reg  <= start_time_next;
                shift_reg       <= shift_next;
                count_reg       <= count_next;
                press_reg       <= press_next;
                press_time_reg  <= press_time_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        matched_reg <= matched_next;
        button_reg  <= button_next;
        raw_reg     <= raw_next;
    end

endmodule

`default_nettype wire

### sv/irpd_checker.sv
`default_nettype none

module irpd_checker
    import irpd_pkg::*;
(
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     in_valid,
    input  wire                     in_ready,
    input  wire                     out_valid,
    input  wire                     out_ready,
    input  wire                     matched,
    input  wire [BUTTON_BITS-1:0]   button,
    input  wire [CODE_BITS-1:0]     raw_code
);

    // A stalled output word must block new edges, or a result could be lost.
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input accepted while output word is stalled");

    a_unmatched_button_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !matched |-> button == '0)
        else $error("unmatched code carries a nonzero button");

    a_button_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && matched |-> button < BUTTON_BITS'(TABLE_SIZE))
        else $error("button index beyond the code table");

    a_output_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(raw_code) && $stable(button))
        else $error("output word changed while stalled");

endmodule

bind ir_pulse_distance_decoder_unit irpd_checker u_irpd_checker (.*);

`default_nettype wire
